// ===== rtl/core/lol_pkg.sv =====
// lol_pkg: shared types and constants for the LRU order list.
// Used by lol_cell and lru_order_list; depends on nothing.

package lol_pkg;

	// default geometry
	localparam int CAPACITY_DEF = 64;
	localparam int ID_BITS_DEF  = 16;

	// fixed field widths of the ports
	localparam int ID_W     = 16;
	localparam int COUNT_W  = 7;
	localparam int MAX_W    = 7;

	// reset value of the length limit
	localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 7'd64;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_DRAG = 1'b1;

	// one request
	typedef struct packed {
		logic            cmd;
		logic [ID_W-1:0] elem_id;
	} req_t;

	// one result
	typedef struct packed {
		logic               was_present;
		logic               evicted;
		logic [ID_W-1:0]    evicted_id;
		logic [COUNT_W-1:0] entry_count;
		logic [ID_W-1:0]    oldest_id;
	} result_t;

	// controls broadcast to every cell
	typedef struct packed {
		logic touch;   // a request is accepted this cycle
		logic insert;  // the id is absent and goes in at the front
		logic trim;    // the entry that lands past the limit is dropped
	} ctl_t;

endpackage

// ===== rtl/core/lol_cell.sv =====
// lol_cell: one position of the LRU order list (id, valid, compare).
// Depends on lol_pkg for the default id width and the broadcast control struct.

module lol_cell #(
	parameter int                 ID_BITS  = lol_pkg::ID_BITS_DEF,
	parameter logic [ID_BITS-1:0] RESET_ID = '0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lol_pkg::ctl_t       ctl,
	input  logic [ID_BITS-1:0]  key,
	input  logic [ID_BITS-1:0]  prev_data,
	input  logic                prev_valid,
	input  logic                next_valid,
	input  logic                hit_in,
	input  logic [ID_BITS-1:0]  tail_in,
	output logic [ID_BITS-1:0]  data,
	output logic                valid,
	output logic                hit_out,
	output logic [ID_BITS-1:0]  tail_out
);

	logic [ID_BITS-1:0] data_q;
	logic               valid_q;
	logic               match;
	logic               prev_last;
	logic               is_tail;

	// compare against the touched id; hits ripple toward the back
	assign match   = valid_q && (data_q == key);
	assign hit_out = hit_in | match;

	// neighbor in front is the tail (for cell 0 this means the list is empty)
	assign prev_last = prev_valid & ~valid_q;

	// tail id collects along the chain
	assign is_tail  = valid_q & ~next_valid;
	assign tail_out = tail_in | (is_tail ? data_q : '0);

	// shift from the front unless the hit lies ahead of this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q  <= RESET_ID;
			valid_q <= 1'b1;
		end else if (ctl.touch) begin
			if (!hit_in) begin
				data_q <= prev_data;
			end
			if (ctl.insert) begin
				valid_q <= prev_valid & ~(ctl.trim & prev_last);
			end
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

// ===== rtl/core/lru_order_list.sv =====
// lru_order_list: top level, a chain of lol_cell positions plus count and result registers.
// Depends on lol_pkg and lol_cell.

// One touch per clock: busy stays low and a request taken at one edge yields its
// result on the next cycle, marked by done for exactly one cycle; the receiver
// cannot stall, so the result must be taken then. The list is a row of CAPACITY
// cells that all compare the id at once and shift toward the back in the same
// cycle, so the compare, the hit chain and the tail pick-up across the row set
// the cycle time. entry_count and oldest_id show the list as it stands after
// the last update. After reset the list is full, id 0 most recent.

module lru_order_list #(
	parameter int CAPACITY = lol_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = lol_pkg::ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  lol_pkg::req_t                req,
	output logic                         done,
	output lol_pkg::result_t             result,
	input  logic                         cfg_we,
	input  logic [lol_pkg::MAX_W-1:0]    cfg_wdata
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > lol_pkg::MAX_W) ? CNT_W : lol_pkg::MAX_W;

	logic [lol_pkg::MAX_W-1:0] max_q;
	logic [CNT_W-1:0]          fill_q;
	logic                      done_q;
	logic                      was_present_q;
	logic                      evicted_q;
	logic [ID_BITS-1:0]        evicted_id_q;

	logic [ID_BITS-1:0]  key;
	logic                touch;
	logic                hit_all;
	logic                full;
	logic                trim;
	logic                evict;
	logic [CMP_W-1:0]    fill_next;
	logic [ID_BITS-1:0]  pre_oldest;
	lol_pkg::ctl_t       ctl;

	logic [ID_BITS-1:0]  dchain [CAPACITY+1];
	logic [CAPACITY+1:0] vchain;
	logic [CAPACITY:0]   hchain;
	logic [ID_BITS-1:0]  tchain [CAPACITY+1];

	assign busy  = 1'b0;
	assign touch = start & ~busy;
	assign key   = ID_BITS'(req.elem_id);

	// chain ends
	assign dchain[0]           = key;
	assign vchain[0]           = 1'b1;
	assign vchain[CAPACITY+1]  = 1'b0;
	assign hchain[0]           = 1'b0;
	assign tchain[0]           = '0;

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lol_cell #(
			.ID_BITS  (ID_BITS),
			.RESET_ID (ID_BITS'(i))
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key),
			.prev_data  (dchain[i]),
			.prev_valid (vchain[i]),
			.next_valid (vchain[i+2]),
			.hit_in     (hchain[i]),
			.tail_in    (tchain[i]),
			.data       (dchain[i+1]),
			.valid      (vchain[i+1]),
			.hit_out    (hchain[i+1]),
			.tail_out   (tchain[i+1])
		);
	end

	// insert / evict decision
	assign hit_all   = hchain[CAPACITY];
	assign full      = (fill_q == CNT_W'(CAPACITY));
	assign fill_next = CMP_W'(fill_q) + CMP_W'(1);
	assign trim      = ~hit_all & ~full & (req.cmd == lol_pkg::CMD_PUSH)
		& (fill_next > CMP_W'(max_q));
	assign evict     = ~hit_all & (full | trim);

	// least recent id before the update; an empty list drops the new id
	assign pre_oldest = (fill_q == '0) ? key : tchain[CAPACITY];

	always_comb begin
		ctl.touch  = touch;
		ctl.insert = ~hit_all;
		ctl.trim   = trim;
	end

	// length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= lol_pkg::MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= CNT_W'(CAPACITY);
		end else if (touch && !hit_all && !full && !trim) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= touch;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (touch) begin
			was_present_q <= hit_all;
			evicted_q     <= evict;
			evicted_id_q  <= evict ? pre_oldest : '0;
		end
	end

	assign done                = done_q;
	assign result.was_present  = was_present_q;
	assign result.evicted      = evicted_q;
	assign result.evicted_id   = lol_pkg::ID_W'(evicted_id_q);
	assign result.entry_count  = lol_pkg::COUNT_W'(fill_q);
	assign result.oldest_id    = lol_pkg::ID_W'(tchain[CAPACITY]);

	// valid bits form a run from the front whose length is the fill count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vchain[CAPACITY:1]) == int'(fill_q))
		else $error("valid bits disagree with fill count");

	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vchain[CAPACITY:1] + CAPACITY'(1)))
		else $error("valid bits not contiguous from the front");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		touch |=> done)
		else $error("accepted request gave no result");

	a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.was_present && result.evicted))
		else $error("eviction reported on a hit");

endmodule

// ===== tb/sv/tb_lru_order_list.sv =====
// tb_lru_order_list: self-checking testbench for the LRU order list.
// Depends on lol_pkg and lru_order_list; predicts each touch and checks every result.

module tb_lru_order_list;
	timeunit 1ns;
	timeprecision 1ps;

	import lol_pkg::*;

	localparam int LIST_DEPTH = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 100000;
	localparam int SEGMENT_ITEMS = 190;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [MAX_W-1:0] cfg_wdata = '0;

	// predictor state: ids in recency order, how many are held, the push limit
	logic [ID_W-1:0] recency_ids [LIST_DEPTH];
	int held_count;
	logic [MAX_W-1:0] length_limit;

	result_t awaited_results [$];
	int errors = 0;
	int cycles = 0;

	lru_order_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// run-length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// list state right after reset: full, id i at position i
	initial begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			recency_ids[i] = i[ID_W-1:0];
		end
		held_count = LIST_DEPTH;
		length_limit = MAX_ENTRIES_RST;
	end

	// apply one touch to the predicted list and return the result it should give
	function automatic result_t apply_touch(input req_t r);
		result_t res;
		logic [ID_W-1:0] id;
		int pos;
		bit hit;
		bit drop;
		logic [ID_W-1:0] drop_id;
		id = r.elem_id;
		pos = 0;
		hit = 1'b0;
		drop = 1'b0;
		drop_id = '0;
		for (int i = 0; i < held_count; i++) begin
			if (!hit && recency_ids[i] == id) begin
				hit = 1'b1;
				pos = i;
			end
		end
		if (hit) begin
			for (int i = pos; i > 0; i--) recency_ids[i] = recency_ids[i-1];
			recency_ids[0] = id;
		end else begin
			// full list: the tail falls off in either mode
			if (held_count >= LIST_DEPTH) begin
				drop = 1'b1;
				drop_id = recency_ids[LIST_DEPTH-1];
				for (int i = LIST_DEPTH - 1; i > 0; i--) recency_ids[i] = recency_ids[i-1];
			end else begin
				for (int i = held_count; i > 0; i--) recency_ids[i] = recency_ids[i-1];
				held_count++;
			end
			recency_ids[0] = id;
			// push over the limit drops exactly one entry
			if (!drop && r.cmd == CMD_PUSH && held_count > int'(length_limit)) begin
				drop = 1'b1;
				drop_id = recency_ids[held_count-1];
				held_count--;
			end
		end
		res.was_present = hit;
		res.evicted = drop;
		res.evicted_id = drop_id;
		res.entry_count = held_count[COUNT_W-1:0];
		res.oldest_id = (held_count > 0) ? recency_ids[held_count-1] : '0;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [ID_W-1:0] exp_val,
			input logic [ID_W-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			errors++;
		end
	endfunction

	// check each result, then record the request or register write taken at this edge
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				exp_res = awaited_results.pop_front();
				check_field("was_present", ID_W'(exp_res.was_present), ID_W'(result.was_present));
				check_field("evicted", ID_W'(exp_res.evicted), ID_W'(result.evicted));
				check_field("evicted_id", exp_res.evicted_id, result.evicted_id);
				check_field("entry_count", ID_W'(exp_res.entry_count), ID_W'(result.entry_count));
				check_field("oldest_id", exp_res.oldest_id, result.oldest_id);
			end
		end
		if (arst_n && start && !busy) awaited_results.push_back(apply_touch(req));
		if (arst_n && cfg_we) length_limit = cfg_wdata;
	end

	function automatic req_t make_req(input logic cmd, input logic [ID_W-1:0] id);
		req_t r;
		r.cmd = cmd;
		r.elem_id = id;
		return r;
	endfunction

	// send one request, idling first with the given chance per cycle
	task automatic send_touch(input req_t item, input int idle_pct);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_limit(input logic [MAX_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// touches at the reset limit: hits at front, tail and middle, misses into a full list
	task automatic test_directed_touches;
		send_touch(make_req(CMD_PUSH, 16'h0000), 0);
		send_touch(make_req(CMD_DRAG, 16'd63), 0);
		send_touch(make_req(CMD_PUSH, 16'hFFFF), 0);
		send_touch(make_req(CMD_DRAG, 16'h8000), 0);
		send_touch(make_req(CMD_PUSH, 16'd32), 0);
		send_touch(make_req(CMD_DRAG, 16'd62), 0);
		send_touch(make_req(CMD_PUSH, 16'hFFFF), 0);
		send_touch(make_req(CMD_PUSH, 16'h0001), 0);
		send_touch(make_req(CMD_DRAG, 16'hFFFE), 0);
		send_touch(make_req(CMD_PUSH, 16'hAAAA), 0);
		send_touch(make_req(CMD_DRAG, 16'h5555), 0);
		drain();
	endtask

	// limit at one, zero, above capacity and back to reset value
	task automatic test_limit_settings;
		write_limit(7'd1);
		send_touch(make_req(CMD_PUSH, 16'h1234), 0);
		send_touch(make_req(CMD_PUSH, 16'd40), 0);
		send_touch(make_req(CMD_DRAG, 16'h4321), 0);
		write_limit(7'd0);
		send_touch(make_req(CMD_PUSH, 16'h0F0F), 0);
		send_touch(make_req(CMD_DRAG, 16'hF0F0), 0);
		write_limit(7'd127);
		send_touch(make_req(CMD_PUSH, 16'h7777), 0);
		send_touch(make_req(CMD_DRAG, 16'h1234), 0);
		write_limit(MAX_ENTRIES_RST);
		send_touch(make_req(CMD_PUSH, 16'h0F0F), 0);
	endtask

	// random touches: mostly ids now in the list or from a small pool, some wide ids
	task automatic test_random_traffic(input logic [MAX_W-1:0] limit, input int idle_pct);
		req_t item;
		int pick;
		write_limit(limit);
		for (int n = 0; n < SEGMENT_ITEMS; n++) begin
			pick = $urandom_range(99, 0);
			item.cmd = $urandom_range(1, 0) ? CMD_DRAG : CMD_PUSH;
			if (pick < 45 && held_count > 0)
				item.elem_id = recency_ids[$urandom_range(held_count - 1, 0)];
			else if (pick < 80)
				item.elem_id = ID_W'($urandom_range(127, 0));
			else
				item.elem_id = ID_W'($urandom());
			send_touch(item, idle_pct);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_touches();
		test_limit_settings();

		// sender idles rarely at first, then often, then never
		test_random_traffic(7'd1, 10);
		test_random_traffic(7'd64, 10);
		test_random_traffic(7'd0, 69);
		test_random_traffic(7'd127, 69);
		test_random_traffic(MAX_W'($urandom_range(63, 2)), 0);
		test_random_traffic(7'd32, 0);

		drain();
		repeat (4) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d results never arrived", awaited_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== lru_order_list.f =====
rtl/core/lol_pkg.sv
rtl/core/lol_cell.sv
rtl/core/lru_order_list.sv
tb/sv/tb_lru_order_list.sv
